[design/pcc_pkg.sv]
// Package for the parity constraint consistency check.
// Holds the stream field layout and the status struct of the find unit.
// No dependencies.
`default_nettype none

package pcc_pkg;

  localparam int NODE_W      = 11;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 8;

  localparam int FIRST_LSB  = 0;
  localparam int SECOND_LSB = 11;
  localparam int DIFFER_BIT = 22;

  typedef struct packed {
    logic done;
    logic par;
  } find_stat_t;

endpackage

`default_nettype wire

[design/pcc_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module pcc_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [W-1:0]             wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[design/pcc_find.sv]
// Find unit: walks a node's link chain to its root, then walks it again
// pointing every node straight at the root. Uses pcc_pkg; drives the link RAM.
`default_nettype none

module pcc_find #(
  parameter int AW = 10
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [AW-1:0]     x,
  input  wire logic [AW:0]       rdata,    // [AW-1:0] link, [AW] parity
  output logic      [AW-1:0]     raddr,
  output logic                   we,
  output logic      [AW-1:0]     waddr,
  output logic      [AW:0]       wdata,    // [AW-1:0] link, [AW] parity
  output logic      [AW-1:0]     root,
  output pcc_pkg::find_stat_t    stat
);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_WALK = 2'd1;
  localparam logic [1:0] F_COMP = 2'd2;

  logic [1:0]    state_r, state_nxt;
  logic [AW-1:0] cur_r, cur_nxt;
  logic [AW-1:0] x_r, x_nxt;
  logic [AW-1:0] root_r, root_nxt;
  logic          p_r, p_nxt;
  logic          cp_r, cp_nxt;

  logic [AW-1:0] link;
  logic          lpar;
  logic          at_root;

  assign link    = rdata[AW-1:0];
  assign lpar    = rdata[AW];
  assign at_root = (link == cur_r);

  always_comb begin
    state_nxt = state_r;
    cur_nxt   = cur_r;
    x_nxt     = x_r;
    root_nxt  = root_r;
    p_nxt     = p_r;
    cp_nxt    = cp_r;
    raddr     = x;
    we        = 1'b0;
    waddr     = cur_r;
    wdata     = {cp_r, root_r};
    case (state_r)
      F_IDLE: begin
        if (start) begin
          raddr     = x;
          cur_nxt   = x;
          x_nxt     = x;
          p_nxt     = 1'b0;
          state_nxt = F_WALK;
        end
      end
      F_WALK: begin
        if (at_root) begin
          root_nxt  = cur_r;
          cp_nxt    = p_r;
          raddr     = x_r;
          cur_nxt   = x_r;
          state_nxt = F_COMP;
        end else begin
          p_nxt   = p_r ^ lpar;
          cur_nxt = link;
          raddr   = link;
        end
      end
      F_COMP: begin
        if (at_root) begin
          state_nxt = F_IDLE;
        end else begin
          we      = 1'b1;
          cp_nxt  = cp_r ^ lpar;
          cur_nxt = link;
          raddr   = link;
        end
      end
      default: begin
        state_nxt = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    cur_r  <= cur_nxt;
    x_r    <= x_nxt;
    root_r <= root_nxt;
    p_r    <= p_nxt;
    cp_r   <= cp_nxt;
  end

  assign root      = root_r;
  assign stat.done = (state_r == F_COMP) && at_root;
  assign stat.par  = p_r;

endmodule

`default_nettype wire

[design/parity_constraint_consistency_check.sv]
// Parity constraint consistency check: parity union-find over a link RAM.
// Uses pcc_pkg, pcc_ram, pcc_find.
// Each accepted constraint runs a find on each node, walking to its root and back
// (few hops after path shortening); a node out of range skips both finds.
// A new constraint is accepted only in idle, once the previous one is done.
// A set's last transaction, and reset, start a clear pass that rewrites every link.
`default_nettype none

module parity_constraint_consistency_check #(
  parameter int NODES = 1024
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // [10:0] first_node, [21:11] second_node, [22] differ, [23] zero
  input  wire logic [pcc_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  wire logic                             in_tlast,   // last_constraint
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // [0] consistent, [7:1] zero
  output logic      [pcc_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  localparam int AW = $clog2(NODES);

  localparam logic [2:0] T_CLEAR = 3'd0;
  localparam logic [2:0] T_IDLE  = 3'd1;
  localparam logic [2:0] T_FA    = 3'd2;
  localparam logic [2:0] T_WA    = 3'd3;
  localparam logic [2:0] T_FB    = 3'd4;
  localparam logic [2:0] T_WB    = 3'd5;
  localparam logic [2:0] T_FIN   = 3'd6;

  logic [2:0]    state_r, state_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [AW-1:0] a_r, a_nxt;
  logic [AW-1:0] b_r, b_nxt;
  logic          d_r, d_nxt;
  logic          last_r, last_nxt;
  logic [AW-1:0] ra_r, ra_nxt;
  logic          pa_r, pa_nxt;
  logic          conflict_r, conflict_nxt;
  logic          ovalid_r, ovalid_nxt;
  logic          cons_r, cons_nxt;

  logic [pcc_pkg::NODE_W-1:0] first_node;
  logic [pcc_pkg::NODE_W-1:0] second_node;
  logic                       in_range;

  logic                 f_start;
  logic [AW-1:0]        f_x;
  logic [AW-1:0]        f_raddr;
  logic                 f_we;
  logic [AW-1:0]        f_waddr;
  logic [AW:0]          f_wdata;
  logic [AW-1:0]        f_root;
  pcc_pkg::find_stat_t  f_stat;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [AW:0]          ram_wdata;
  logic [AW:0]          ram_rdata;

  assign first_node  = in_tdata[pcc_pkg::FIRST_LSB +: pcc_pkg::NODE_W];
  assign second_node = in_tdata[pcc_pkg::SECOND_LSB +: pcc_pkg::NODE_W];
  assign in_range    = (first_node != '0) && (32'(first_node) <= NODES) &&
                       (second_node != '0) && (32'(second_node) <= NODES);

  assign in_tready = (state_r == T_IDLE);
  assign f_start   = (state_r == T_FA) || (state_r == T_FB);
  assign f_x       = (state_r == T_FB) ? b_r : a_r;

  always_comb begin
    state_nxt    = state_r;
    clr_nxt      = clr_r;
    a_nxt        = a_r;
    b_nxt        = b_r;
    d_nxt        = d_r;
    last_nxt     = last_r;
    ra_nxt       = ra_r;
    pa_nxt       = pa_r;
    conflict_nxt = conflict_r;
    ovalid_nxt   = ovalid_r && !out_tready;
    cons_nxt     = cons_r;
    ram_we       = f_we;
    ram_waddr    = f_waddr;
    ram_wdata    = f_wdata;
    case (state_r)
      T_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = {1'b0, clr_r};
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == AW'(NODES - 1)) begin
          state_nxt = T_IDLE;
        end
      end
      T_IDLE: begin
        if (in_tvalid) begin
          a_nxt     = AW'(first_node - 1'b1);
          b_nxt     = AW'(second_node - 1'b1);
          d_nxt     = in_tdata[pcc_pkg::DIFFER_BIT];
          last_nxt  = in_tlast;
          state_nxt = in_range ? T_FA : T_FIN;
        end
      end
      T_FA: begin
        state_nxt = T_WA;
      end
      T_WA: begin
        if (f_stat.done) begin
          ra_nxt    = f_root;
          pa_nxt    = f_stat.par;
          state_nxt = T_FB;
        end
      end
      T_FB: begin
        state_nxt = T_WB;
      end
      T_WB: begin
        if (f_stat.done) begin
          if (f_root == ra_r) begin
            if ((pa_r ^ f_stat.par) != d_r) begin
              conflict_nxt = 1'b1;
            end
          end else begin
            ram_we    = 1'b1;
            ram_waddr = ra_r;
            ram_wdata = {pa_r ^ f_stat.par ^ d_r, f_root};
          end
          state_nxt = T_FIN;
        end
      end
      T_FIN: begin
        if (!last_r) begin
          state_nxt = T_IDLE;
        end else if (!ovalid_r || out_tready) begin
          ovalid_nxt   = 1'b1;
          cons_nxt     = !conflict_r;
          conflict_nxt = 1'b0;
          clr_nxt      = '0;
          state_nxt    = T_CLEAR;
        end
      end
      default: begin
        clr_nxt   = '0;
        state_nxt = T_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= T_CLEAR;
      clr_r      <= '0;
      conflict_r <= 1'b0;
      ovalid_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_r      <= clr_nxt;
      conflict_r <= conflict_nxt;
      ovalid_r   <= ovalid_nxt;
    end
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    d_r    <= d_nxt;
    last_r <= last_nxt;
    ra_r   <= ra_nxt;
    pa_r   <= pa_nxt;
    cons_r <= cons_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = {{(pcc_pkg::OUT_TDATA_W-1){1'b0}}, cons_r};

  pcc_find #(
    .AW(AW)
  ) u_find (
    .clk   (clk),
    .rst_n (rst_n),
    .start (f_start),
    .x     (f_x),
    .rdata (ram_rdata),
    .raddr (f_raddr),
    .we    (f_we),
    .waddr (f_waddr),
    .wdata (f_wdata),
    .root  (f_root),
    .stat  (f_stat)
  );

  pcc_ram #(
    .W     (AW + 1),
    .DEPTH (NODES)
  ) u_links (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (f_raddr),
    .rdata (ram_rdata)
  );

endmodule

`default_nettype wire
